>>> hw/rtl/cla_pkg.sv
// Package for the classifier loss and accuracy block: widths, constants and types.
`default_nettype none

package cla_pkg;

  // Field widths of the streams.
  localparam int SCORE_W = 17;
  localparam int LABEL_W = 8;
  localparam int NCLASS_W = 9;
  localparam int LOSS_W = 32;
  localparam int COUNT_W = 16;

  // Classes per sample and score format.
  localparam int MAX_CLASSES = 256;
  localparam int POS_W = $clog2(MAX_CLASSES);
  localparam int SCORE_FRAC_BITS = 15;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = NCLASS_W;
  localparam logic [CFG_INDEX_W-1:0] REG_LOSS_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_CLASSES = 1'd1;
  localparam logic [NCLASS_W-1:0] NUM_CLASSES_RESET = 9'd10;

  // Loss modes.
  localparam logic MODE_CROSS_ENTROPY = 1'b0;
  localparam logic MODE_SQUARED = 1'b1;

  // Log2 datapath: the argument is normalized into a 32-bit mantissa and each
  // squaring step yields one fraction bit of the result.
  localparam int X_W = SCORE_FRAC_BITS + 1;
  localparam int K_W = $clog2(X_W);
  localparam int M_W = 32;
  localparam int LOG_FRAC = 16;
  localparam int L_W = K_W + LOG_FRAC;
  localparam int LN2_W = 32;
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam int PROD_W = L_W + LN2_W;

  // -ln(1e-8) in Q16.16, the cap on one cross-entropy term.
  localparam logic [LOSS_W-1:0] CE_FLOOR_Q16 = 32'd1207218;

  // Squared term: (diff^2) >> (2F-15) with the half folded in.
  localparam int DIFF_W = SCORE_W + 1;
  localparam int SQ_SHIFT = 2 * SCORE_FRAC_BITS - 15;
  localparam int SQP_W = 2 * DIFF_W + 1;

  // Pipeline stage positions.
  localparam int ST_LN = LOG_FRAC + 1;
  localparam int ST_TERM = LOG_FRAC + 2;
  localparam int ST_OUT = LOG_FRAC + 3;
  localparam int NSTG = LOG_FRAC + 4;

  // Per-element values carried down the pipeline next to the log datapath.
  typedef struct packed {
    logic signed [SCORE_W-1:0] grad;
    logic send;
    logic correct;
    logic bend;
    logic is_label;
    logic ce_floor;
    logic [DIFF_W-1:0] sq_abs;
  } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/classifier_loss_and_accuracy.sv
// Classifier loss and accuracy: gradient, batch loss and argmax hit count per element.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_ready, score, label, batch_end    | in
//   output  | out_valid, out_ready, gradient, sample_end,    | out
//           | sample_correct, batch_done, batch_loss,         |
//           | correct_count                                  |
//   config  | cfg_write, cfg_index, cfg_data                 | in
//
// One request enters per cycle unless the pipeline is stalled; its result passes the input
// register, the 16 squaring stages of the log2 unit and the ln2 product and term stages
// and is registered in the output stage. Synchronous reset clears the valid bits,
// the sample state and the totals. Each stage holds when the next one is full and
// stalled, so bubbles close up and requests keep entering while a result waits,
// until all 20 stages are full.
`default_nettype none

module classifier_loss_and_accuracy (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [cla_pkg::SCORE_W-1:0]     score,
  input  wire logic [cla_pkg::LABEL_W-1:0]            label,
  input  wire logic                                   batch_end,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [cla_pkg::SCORE_W-1:0]          gradient,
  output logic                                        sample_end,
  output logic                                        sample_correct,
  output logic                                        batch_done,
  output logic [cla_pkg::LOSS_W-1:0]                  batch_loss,
  output logic [cla_pkg::COUNT_W-1:0]                 correct_count,
  input  wire logic                                   cfg_write,
  input  wire logic [cla_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [cla_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import cla_pkg::*;

  localparam int CMP_W = (POS_W + 1 > NCLASS_W) ? POS_W + 1 : NCLASS_W;
  localparam int LBL_W = (POS_W > LABEL_W) ? POS_W : LABEL_W;

  // Configuration registers.
  logic loss_mode;
  logic [NCLASS_W-1:0] num_classes;

  // Sample state.
  logic [POS_W-1:0] class_position;
  logic signed [SCORE_W-1:0] best_score;
  logic [POS_W-1:0] best_class;

  // Batch totals.
  logic [LOSS_W-1:0] loss_total;
  logic [COUNT_W-1:0] hit_total;

  // Pipeline.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  side_t side [ST_TERM+1];
  logic [M_W-1:0] mant [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] frac [LOG_FRAC+1];
  logic [K_W-1:0] expo [LOG_FRAC+1];
  logic [PROD_W-1:0] ln_prod;
  logic [LOSS_W-1:0] term;

  // Front-end values.
  logic [CMP_W-1:0] n_eff;
  logic [CMP_W-1:0] pos_plus;
  logic is_label;
  logic signed [DIFF_W-1:0] target;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] grad_wide;
  logic take_best;
  logic [POS_W-1:0] best_class_next;
  logic send;
  logic accept;
  logic [X_W-1:0] x_clamp;
  logic [K_W-1:0] k_in;
  logic [4:0] norm_sh;
  side_t side_in;

  // Squaring stages.
  logic [2*M_W-1:0] sq_prod [LOG_FRAC];
  logic [M_W:0] sq_top [LOG_FRAC];
  logic [M_W-1:0] mant_next [LOG_FRAC];
  logic frac_bit [LOG_FRAC];

  // Later stages.
  logic [L_W-1:0] log_val;
  logic [L_W-1:0] log_full;
  logic [L_W-1:0] log_diff;
  logic [PROD_W:0] ln_rnd;
  logic [PROD_W-LN2_W:0] ce_raw;
  logic [LOSS_W-1:0] ce_term;
  logic [2*DIFF_W-1:0] sq_sq;
  logic [SQP_W-1:0] sq_rnd;
  logic [SQP_W-1:0] sq_q;
  logic [LOSS_W-1:0] sq_term;
  logic [LOSS_W-1:0] term_next;
  logic [LOSS_W:0] loss_sum;
  logic [LOSS_W-1:0] loss_next;
  logic [COUNT_W-1:0] hit_next;
  logic out_load;

  // Each stage takes new data when it is empty or its contents move on.
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];
  assign accept = in_valid && rdy[0];
  assign out_valid = vld[ST_OUT];
  assign out_load = vld[ST_TERM] && rdy[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_mode <= MODE_CROSS_ENTROPY;
      num_classes <= NUM_CLASSES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOSS_MODE:   loss_mode <= cfg_data[0];
        REG_NUM_CLASSES: num_classes <= cfg_data[NCLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: position, target, gradient, argmax and log2 normalization.
  always_comb begin
    if (num_classes == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(num_classes) > CMP_W'(MAX_CLASSES)) begin
      n_eff = CMP_W'(MAX_CLASSES);
    end else begin
      n_eff = CMP_W'(num_classes);
    end
    pos_plus = CMP_W'(class_position) + CMP_W'(1);
    is_label = (LBL_W'(class_position) == LBL_W'(label));
    target = is_label ? (DIFF_W'(1) <<< SCORE_FRAC_BITS) : '0;
    diff = DIFF_W'(score) - target;
    grad_wide = target - DIFF_W'(score);

    take_best = (score > best_score);
    best_class_next = take_best ? class_position : best_class;
    send = (pos_plus >= n_eff) || batch_end;

    x_clamp = '0;
    if (score > (SCORE_W'(1) <<< SCORE_FRAC_BITS)) begin
      x_clamp = X_W'(1) << SCORE_FRAC_BITS;
    end else if (score > 0) begin
      x_clamp = score[X_W-1:0];
    end
    k_in = '0;
    for (int b = 0; b < X_W; b++) begin
      if (x_clamp[b]) begin
        k_in = K_W'(b);
      end
    end
    norm_sh = 5'(M_W - 1) - 5'(k_in);

    side_in.grad = (grad_wide > DIFF_W'(65535)) ? SCORE_W'(65535)
                 : (grad_wide < -DIFF_W'(65536)) ? SCORE_W'(-65536)
                 : grad_wide[SCORE_W-1:0];
    side_in.send = send;
    side_in.correct = send && (LBL_W'(best_class_next) == LBL_W'(label));
    side_in.bend = batch_end;
    side_in.is_label = is_label;
    side_in.ce_floor = (score <= 0);
    side_in.sq_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_position <= '0;
      best_score <= '0;
      best_class <= '0;
    end else if (accept) begin
      if (send) begin
        class_position <= '0;
        best_score <= '0;
        best_class <= '0;
      end else begin
        class_position <= pos_plus[POS_W-1:0];
        if (take_best) begin
          best_score <= score;
          best_class <= class_position;
        end
      end
    end
  end

  // One squaring per stage gives one fraction bit of log2.
  always_comb begin
    for (int i = 0; i < LOG_FRAC; i++) begin
      sq_prod[i] = mant[i] * mant[i];
      sq_top[i] = sq_prod[i][2*M_W-1:M_W-1];
      frac_bit[i] = sq_top[i][M_W];
      mant_next[i] = sq_top[i][M_W] ? sq_top[i][M_W:1] : sq_top[i][M_W-1:0];
    end
  end

  // -ln(x) = (F - log2 x) * ln2, and the squared-error term.
  always_comb begin
    log_val = {expo[LOG_FRAC], frac[LOG_FRAC]};
    log_full = L_W'(SCORE_FRAC_BITS) << LOG_FRAC;
    log_diff = (log_full > log_val) ? log_full - log_val : '0;

    ln_rnd = (PROD_W+1)'(ln_prod) + ((PROD_W+1)'(1) << (LN2_W - 1));
    ce_raw = ln_rnd[PROD_W:LN2_W];
    if (side[ST_LN].ce_floor || ((PROD_W-LN2_W+1)'(CE_FLOOR_Q16) < ce_raw)) begin
      ce_term = CE_FLOOR_Q16;
    end else begin
      ce_term = LOSS_W'(ce_raw);
    end

    sq_sq = side[ST_LN].sq_abs * side[ST_LN].sq_abs;
    sq_rnd = SQP_W'(sq_sq) + (SQP_W'(1) << (SQ_SHIFT - 1));
    sq_q = sq_rnd >> SQ_SHIFT;
    sq_term = (|(sq_q >> LOSS_W)) ? '1 : sq_q[LOSS_W-1:0];

    if (loss_mode == MODE_SQUARED) begin
      term_next = sq_term;
    end else begin
      term_next = side[ST_LN].is_label ? ce_term : '0;
    end
  end

  // Totals including the element in the term stage.
  always_comb begin
    loss_sum = {1'b0, loss_total} + {1'b0, term};
    loss_next = loss_sum[LOSS_W] ? '1 : loss_sum[LOSS_W-1:0];
    if (side[ST_TERM].correct && (hit_total != '1)) begin
      hit_next = hit_total + COUNT_W'(1);
    end else begin
      hit_next = hit_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side[0] <= side_in;
      mant[0] <= M_W'(x_clamp) << norm_sh;
      frac[0] <= '0;
      expo[0] <= k_in;
    end
    for (int i = 1; i <= LOG_FRAC; i++) begin
      if (rdy[i]) begin
        side[i] <= side[i-1];
        mant[i] <= mant_next[i-1];
        frac[i] <= {frac[i-1][LOG_FRAC-2:0], frac_bit[i-1]};
        expo[i] <= expo[i-1];
      end
    end
    if (rdy[ST_LN]) begin
      side[ST_LN] <= side[ST_LN-1];
      ln_prod <= PROD_W'(log_diff) * PROD_W'(LN2_Q32);
    end
    if (rdy[ST_TERM]) begin
      side[ST_TERM] <= side[ST_LN];
      term <= term_next;
    end
    if (out_load) begin
      gradient <= side[ST_TERM].grad;
      sample_end <= side[ST_TERM].send;
      sample_correct <= side[ST_TERM].correct;
      batch_done <= side[ST_TERM].bend;
      batch_loss <= loss_next;
      correct_count <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_total <= '0;
      hit_total <= '0;
    end else if (out_load) begin
      if (side[ST_TERM].bend) begin
        loss_total <= '0;
        hit_total <= '0;
      end else begin
        loss_total <= loss_next;
        hit_total <= hit_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/classifier_loss_and_accuracy_tb.sv
// Self-checking testbench for the classifier loss and accuracy block.
module classifier_loss_and_accuracy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cla_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 1500;
  localparam int BURST_ITEMS = 250;
  localparam longint RUN_LIMIT_NS = 20_000_000;
  localparam longint GRAD_HI = (longint'(1) << (SCORE_W - 1)) - 1;
  localparam longint GRAD_LO = -(longint'(1) << (SCORE_W - 1));
  localparam longint unsigned LOSS_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [SCORE_W-1:0] grad;
    logic closes;
    logic hit;
    logic closes_batch;
    logic [LOSS_W-1:0] loss;
    logic [COUNT_W-1:0] hits;
  } elem_outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [SCORE_W-1:0] score;
  logic [LABEL_W-1:0] label;
  logic batch_end;
  logic out_valid;
  logic out_ready;
  logic signed [SCORE_W-1:0] gradient;
  logic sample_end;
  logic sample_correct;
  logic batch_done;
  logic [LOSS_W-1:0] batch_loss;
  logic [COUNT_W-1:0] correct_count;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block's registers and per-sample state.
  logic mdl_mode = MODE_CROSS_ENTROPY;
  logic [NCLASS_W-1:0] mdl_nclass = NUM_CLASSES_RESET;
  logic [POS_W-1:0] cls_pos = '0;
  logic signed [SCORE_W-1:0] top_score = '0;
  logic [POS_W-1:0] top_class = '0;
  logic [LOSS_W-1:0] loss_acc = '0;
  logic [COUNT_W-1:0] hit_acc = '0;

  elem_outcome_t outcome_queue[$];
  bit idle_on = 1'b1;
  int fail_count = 0;
  int sent_total = 0;
  int checked_total = 0;
  int batch_total = 0;
  int correct_total = 0;

  classifier_loss_and_accuracy dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .score(score),
    .label(label),
    .batch_end(batch_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gradient(gradient),
    .sample_end(sample_end),
    .sample_correct(sample_correct),
    .batch_done(batch_done),
    .batch_loss(batch_loss),
    .correct_count(correct_count),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // -ln(score) in Q16.16 via a log2 built from repeated squaring.
  function automatic longint unsigned ce_term(input longint sv);
    longint unsigned x, m, lg, d, t;
    int k, i;
    if (sv <= 0) return CE_FLOOR_Q16;
    x = sv;
    if (x > (64'd1 << SCORE_FRAC_BITS)) x = 64'd1 << SCORE_FRAC_BITS;
    k = SCORE_FRAC_BITS;
    while (k > 0 && x[k] == 1'b0) k--;
    m = x << (31 - k);
    lg = 0;
    // Each squaring of the normalized mantissa yields one fraction bit.
    for (i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      lg = lg << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        lg = lg | 64'd1;
      end
    end
    lg = lg | (longint'(k) << LOG_FRAC);
    d = (64'(SCORE_FRAC_BITS) << LOG_FRAC);
    d = (d > lg) ? d - lg : 0;
    t = (d * LN2_Q32 + (64'd1 << 31)) >> 32;
    return (t > CE_FLOOR_Q16) ? CE_FLOOR_Q16 : t;
  endfunction

  function automatic longint unsigned sq_term(input longint diff);
    longint unsigned a, q;
    a = (diff < 0) ? -diff : diff;
    q = (a * a + (64'd1 << (SQ_SHIFT - 1))) >> SQ_SHIFT;
    return (q > LOSS_MAX) ? LOSS_MAX : q;
  endfunction

  function automatic elem_outcome_t score_element(input logic signed [SCORE_W-1:0] s,
                                                  input logic [LABEL_W-1:0] lbl,
                                                  input logic bend);
    elem_outcome_t r;
    int n;
    longint sv, tgt, g;
    longint unsigned term, sum;
    logic at_label;
    n = mdl_nclass;
    if (n == 0) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    sv = s;
    at_label = (cls_pos == lbl);
    tgt = at_label ? (longint'(1) << SCORE_FRAC_BITS) : 0;
    g = tgt - sv;
    if (g > GRAD_HI) g = GRAD_HI;
    if (g < GRAD_LO) g = GRAD_LO;
    term = 0;
    if (mdl_mode == MODE_CROSS_ENTROPY) begin
      if (at_label) term = ce_term(sv);
    end else begin
      term = sq_term(sv - tgt);
    end
    sum = loss_acc + term;
    loss_acc = (sum > LOSS_MAX) ? LOSS_MAX[LOSS_W-1:0] : sum[LOSS_W-1:0];
    if (s > top_score) begin
      top_score = s;
      top_class = cls_pos;
    end
    r.closes = (int'(cls_pos) + 1 >= n) || bend;
    r.hit = 1'b0;
    if (r.closes) begin
      r.hit = (top_class == lbl);
      if (r.hit && hit_acc != '1) hit_acc++;
      cls_pos = '0;
      top_score = '0;
      top_class = '0;
    end else begin
      cls_pos++;
    end
    r.grad = g[SCORE_W-1:0];
    r.closes_batch = bend;
    r.loss = loss_acc;
    r.hits = hit_acc;
    if (bend) begin
      loss_acc = '0;
      hit_acc = '0;
    end
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score(input bit favored);
    logic signed [SCORE_W-1:0] v;
    if (favored) return SCORE_W'($urandom_range(16384, 40000));
    case ($urandom_range(0, 5))
      0: v = SCORE_W'($urandom);
      1: v = SCORE_W'($urandom_range(0, 32768));
      2: v = SCORE_W'(17'h10000 | $urandom_range(0, 65535));
      3: v = '0;
      4: v = $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000;
      default: v = SCORE_W'($urandom_range(0, 2000));
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic push_element(input logic signed [SCORE_W-1:0] s,
                              input logic [LABEL_W-1:0] lbl, input logic bend);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    score <= s;
    label <= lbl;
    batch_end <= bend;
    do @(posedge clk); while (!in_ready);
    outcome_queue.push_back(score_element(s, lbl, bend));
    sent_total++;
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (outcome_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic mode_v, input logic [CFG_DATA_W-1:0] nclass_v);
    cfg_write <= 1'b1;
    cfg_index <= REG_LOSS_MODE;
    cfg_data <= CFG_DATA_W'(mode_v);
    @(posedge clk);
    cfg_index <= REG_NUM_CLASSES;
    cfg_data <= nclass_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    mdl_mode = mode_v;
    mdl_nclass = nclass_v;
  endtask

  // Reset configuration: field extremes, score above one at the label,
  // and a batch end that cuts a sample short.
  task automatic test_reset_defaults();
    int first_scores[10] = '{-65536, 65535, 0, 1, 32768, -1, 32767, 16384, 100, -200};
    int i;
    for (i = 0; i < 10; i++) push_element(17'(first_scores[i]), 8'd1, 1'b0);
    push_element(17'sd0, 8'd0, 1'b0);
    push_element(-17'sd5, 8'd0, 1'b0);
    push_element(-17'sd7, 8'd0, 1'b1);
    settle();
  endtask

  task automatic test_class_count_corners();
    program_regs(MODE_SQUARED, 9'd0);
    push_element(17'sd0, 8'd0, 1'b0);
    push_element(17'h10000, 8'd255, 1'b0);
    push_element(17'h0FFFF, 8'd0, 1'b1);
    settle();
    program_regs(MODE_CROSS_ENTROPY, 9'd511);
    push_element(17'sd32768, 8'd255, 1'b0);
    push_element(-17'sd1, 8'd255, 1'b0);
    push_element(17'sd7, 8'd255, 1'b1);
    settle();
  endtask

  // Shrinking the class count below the current position closes the sample
  // on the next element.
  task automatic test_count_change();
    program_regs(MODE_CROSS_ENTROPY, 9'd6);
    push_element(17'sd10, 8'd2, 1'b0);
    push_element(17'sd20, 8'd2, 1'b0);
    push_element(17'sd30000, 8'd2, 1'b0);
    push_element(17'sd5, 8'd2, 1'b0);
    settle();
    program_regs(MODE_CROSS_ENTROPY, 9'd3);
    push_element(17'sd1000, 8'd2, 1'b0);
    push_element(17'sd200, 8'd1, 1'b0);
    push_element(17'sd9000, 8'd1, 1'b0);
    push_element(-17'sd300, 8'd1, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic();
    int first, phase, n_eff, batches, samples, len, sn, el;
    logic [CFG_DATA_W-1:0] ncfg;
    logic mode_v;
    logic [LABEL_W-1:0] lbl;
    logic bend, leave_open, last_sample;
    first = sent_total;
    phase = 0;
    while (sent_total - first < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: ncfg = 9'd1;
        1: ncfg = 9'd0;
        2: ncfg = 9'd256;
        3: ncfg = 9'd511;
        default: begin
          case ($urandom_range(0, 19))
            0, 1: ncfg = 9'd0;
            2: ncfg = CFG_DATA_W'($urandom_range(256, 511));
            3, 4, 5: ncfg = CFG_DATA_W'($urandom_range(13, 64));
            default: ncfg = CFG_DATA_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      mode_v = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      program_regs(mode_v, ncfg);
      idle_on = ($urandom_range(0, 4) != 0);
      leave_open = ($urandom_range(0, 5) == 0);
      n_eff = (ncfg == 0) ? 1 : ((ncfg > MAX_CLASSES) ? MAX_CLASSES : ncfg);
      batches = (n_eff > 64) ? 1 : $urandom_range(1, 3);
      repeat (batches) begin
        samples = (n_eff > 64) ? 1 : $urandom_range(1, 6);
        for (sn = 0; sn < samples; sn++) begin
          last_sample = (sn == samples - 1);
          lbl = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, n_eff - 1));
          len = n_eff;
          if (last_sample && $urandom_range(0, (n_eff > 64) ? 1 : 7) == 0)
            len = $urandom_range(1, n_eff);
          for (el = 0; el < len; el++) begin
            bend = last_sample && (el == len - 1) && !leave_open;
            if ($urandom_range(0, 49) == 0) bend = 1'b1;
            push_element(pick_score(el == lbl && $urandom_range(0, 2) != 0),
                         ($urandom_range(0, 29) == 0) ? 8'($urandom) : lbl, bend);
          end
        end
      end
      phase++;
    end
    settle();
  endtask

  // A closing batch of floor-valued cross-entropy terms, one class per sample,
  // with no idling on either side.
  task automatic test_idle_free_burst();
    int i;
    idle_on = 1'b0;
    program_regs(MODE_CROSS_ENTROPY, 9'd1);
    for (i = 0; i < BURST_ITEMS; i++)
      push_element((i % 4 == 0) ? 17'sd0 : SCORE_W'(17'h10000 | $urandom_range(0, 65535)),
                   8'd0, i == BURST_ITEMS - 1);
    settle();
  endtask

  initial begin : ready_driver
    int span;
    out_ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 13);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    elem_outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (outcome_queue.size() == 0) begin
        $error("result with no request outstanding: gradient %0d", gradient);
        fail_count++;
      end else begin
        want = outcome_queue.pop_front();
        check_field("gradient", want.grad, gradient);
        check_field("sample_end", want.closes, sample_end);
        check_field("sample_correct", want.hit, sample_correct);
        check_field("batch_done", want.closes_batch, batch_done);
        check_field("batch_loss", want.loss, batch_loss);
        check_field("correct_count", want.hits, correct_count);
        checked_total++;
        if (batch_done) batch_total++;
        if (sample_correct) correct_total++;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("classifier_loss_and_accuracy verification failed");
    $finish;
  end

  initial begin : main_sequence
    rst = 1'b1;
    in_valid = 1'b0;
    score = '0;
    label = '0;
    batch_end = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_LOSS_MODE;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_class_count_corners();
    test_count_change();
    test_random_traffic();
    test_idle_free_burst();
    $display("Ran %0d requests, %0d results compared, both loss modes, class counts 0-511.",
             sent_total, checked_total);
    $display("Saw %0d batch closes and %0d correct samples; the run ends with no idling.",
             batch_total, correct_total);
    if (fail_count == 0) begin
      $display("classifier_loss_and_accuracy verification clean");
    end else begin
      $display("classifier_loss_and_accuracy verification failed");
    end
    $finish;
  end

endmodule
